// File: hw/rtl/force_peak_break_detector_defines.svh
// Assertion macros shared by the checker of the force peak and break detector.
`ifndef FORCE_PEAK_BREAK_DETECTOR_DEFINES_SVH
`define FORCE_PEAK_BREAK_DETECTOR_DEFINES_SVH

// Property that is checked only outside reset.
`define FPBD_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property that is checked during reset as well.
`define FPBD_CHECK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/fpbd_pkg.sv
// Types, widths and defaults of the force peak and break detector.
`default_nettype none

package fpbd_pkg;

  localparam int DEF_TARE_SAMPLES = 20;
  localparam int DEF_SAMPLE_BITS  = 24;

  localparam int FORCE_W    = 24;
  localparam int CFG_W      = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int DEBOUNCE_W = 10;
  localparam int SETTLE_W   = 12;
  localparam int PHASE_W    = 2;

  localparam logic [FORCE_W-1:0]    FORCE_MAX    = '1;
  localparam logic [DEBOUNCE_W-1:0] SINCE_MAX    = '1;
  localparam logic [SETTLE_W-1:0]   SETTLE_MAX   = '1;

  localparam logic [FORCE_W-1:0]    DEF_DEADBAND = 24'd75;
  localparam logic [FORCE_W-1:0]    DEF_BREAK    = 24'd10000;
  localparam logic [DEBOUNCE_W-1:0] DEF_DEBOUNCE = 10'd40;
  localparam logic [SETTLE_W-1:0]   DEF_SETTLE   = 12'd750;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEADBAND = 2'd0,
    CFG_BREAK    = 2'd1,
    CFG_DEBOUNCE = 2'd2,
    CFG_SETTLE   = 2'd3
  } cfg_index_t;

  typedef enum logic [PHASE_W-1:0] {
    PH_SETTLE = 2'd0,
    PH_TARE   = 2'd1,
    PH_RUN    = 2'd2,
    PH_BROKEN = 2'd3
  } phase_t;

endpackage

`default_nettype wire

// File: hw/rtl/force_peak_break_detector.sv
// Top level of the force peak and break detector for a load-cell tensile tester.
// The result of a request is registered at the edge that accepts it.
// Throughput: one request per cycle; a stalled result stalls the input side only while
// the result register is full.
// The tare average uses one constant reciprocal multiplication on the last tare request.
// Reset is synchronous: registers return to their defaults and the block starts settling.
`default_nettype none

module force_peak_break_detector
  import fpbd_pkg::*;
#(
  parameter int TARE_SAMPLES = DEF_TARE_SAMPLES,
  parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_write,
  input  wire [CFG_IDX_W-1:0]          cfg_index,
  input  wire [CFG_W-1:0]              cfg_data,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire                          button_level,
  input  wire                          ms_tick,
  input  wire                          sample_valid,
  input  wire signed [SAMPLE_BITS-1:0] raw_sample,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [PHASE_W-1:0]           phase,
  output logic [FORCE_W-1:0]           force_counts,
  output logic [FORCE_W-1:0]           peak_counts,
  output logic [FORCE_W-1:0]           break_force,
  output logic                         break_event,
  output logic signed [FORCE_W-1:0]    zero_offset
);

  localparam int CNT_W    = $clog2(TARE_SAMPLES + 1);
  localparam int SUM_W    = SAMPLE_BITS + CNT_W;
  localparam int SHIFT    = SUM_W + $clog2(TARE_SAMPLES);
  localparam int RECIP_W  = SUM_W + 1;
  localparam int PROD_W   = SUM_W + RECIP_W;
  localparam int REL_W    = SAMPLE_BITS + 1;
  localparam int MAG_W    = SAMPLE_BITS + FORCE_W;
  localparam int EXT_W    = SAMPLE_BITS + FORCE_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << SHIFT)
      + 64'(TARE_SAMPLES) - 64'd1) / 64'(TARE_SAMPLES));

  logic [FORCE_W-1:0]    deadband_counts;
  logic [FORCE_W-1:0]    break_counts;
  logic [DEBOUNCE_W-1:0] debounce_limit;
  logic [SETTLE_W-1:0]   settle_ms;

  phase_t                        phase_reg, phase_reg_next;
  logic [SETTLE_W-1:0]           settle_count, settle_count_next;
  logic [CNT_W-1:0]              tare_count, tare_count_next;
  logic signed [SUM_W-1:0]       tare_sum, tare_sum_next;
  logic signed [SAMPLE_BITS-1:0] offset_reg, offset_reg_next;
  logic [FORCE_W-1:0]            force_reg, force_reg_next;
  logic [FORCE_W-1:0]            peak_reg, peak_reg_next;
  logic [FORCE_W-1:0]            break_reg, break_reg_next;
  logic                          last_raw_level, last_raw_level_next;
  logic                          stable_level, stable_level_next;
  logic [DEBOUNCE_W-1:0]         since_change_ms, since_change_ms_next;
  logic                          brk_reg, brk_reg_next;

  logic                          accept;
  logic                          pressed;
  logic signed [SUM_W-1:0]       tare_add;
  logic [SUM_W-1:0]              tare_abs;
  logic [PROD_W-1:0]             tare_prod;
  logic [SAMPLE_BITS-1:0]        tare_mag;
  logic signed [SAMPLE_BITS-1:0] tare_quot;
  logic signed [REL_W-1:0]       rel;
  logic [REL_W-1:0]              rel_abs;
  logic [MAG_W-1:0]              mag_ext;
  logic [FORCE_W-1:0]            force_sat;
  logic [FORCE_W-1:0]            force_db;
  logic signed [EXT_W-1:0]       offset_ext;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // Tare average: exact truncating division by a constant through its reciprocal.
  assign tare_add  = tare_sum + SUM_W'(raw_sample);
  assign tare_abs  = tare_add[SUM_W-1] ? SUM_W'(-tare_add) : SUM_W'(tare_add);
  assign tare_prod = PROD_W'(tare_abs) * PROD_W'(RECIP);
  assign tare_mag  = tare_prod[SHIFT +: SAMPLE_BITS];
  assign tare_quot = tare_add[SUM_W-1] ? SAMPLE_BITS'(-tare_mag) : SAMPLE_BITS'(tare_mag);

  assign rel       = REL_W'(raw_sample) - REL_W'(offset_reg);
  assign rel_abs   = rel[REL_W-1] ? REL_W'(-rel) : REL_W'(rel);
  assign mag_ext   = MAG_W'(rel_abs);
  assign force_sat = (mag_ext > MAG_W'(FORCE_MAX)) ? FORCE_MAX : mag_ext[FORCE_W-1:0];
  assign force_db  = (force_sat < deadband_counts) ? '0 : force_sat;

  always_comb begin
    last_raw_level_next  = last_raw_level;
    since_change_ms_next = since_change_ms;
    stable_level_next    = stable_level;
    pressed              = 1'b0;
    phase_reg_next       = phase_reg;
    settle_count_next    = settle_count;
    tare_count_next      = tare_count;
    tare_sum_next        = tare_sum;
    offset_reg_next      = offset_reg;
    force_reg_next       = force_reg;
    peak_reg_next        = peak_reg;
    break_reg_next       = break_reg;
    brk_reg_next         = 1'b0;

    if (button_level != last_raw_level) begin
      last_raw_level_next  = button_level;
      since_change_ms_next = '0;
    end else if (ms_tick && since_change_ms != SINCE_MAX) begin
      since_change_ms_next = since_change_ms + 1'b1;
    end
    if (since_change_ms_next >= debounce_limit && button_level != stable_level) begin
      stable_level_next = button_level;
      pressed           = !button_level;
    end

    case (phase_reg)
      PH_SETTLE: begin
        if (ms_tick && settle_count != SETTLE_MAX) begin
          settle_count_next = settle_count + 1'b1;
        end
        if (settle_count_next >= settle_ms) begin
          phase_reg_next = PH_TARE;
        end
      end
      PH_TARE: begin
        if (sample_valid) begin
          tare_sum_next   = tare_add;
          tare_count_next = tare_count + 1'b1;
          if (tare_count_next >= CNT_W'(TARE_SAMPLES)) begin
            offset_reg_next = tare_quot;
            force_reg_next  = '0;
            peak_reg_next   = '0;
            break_reg_next  = '0;
            phase_reg_next  = PH_RUN;
          end
        end
      end
      PH_RUN: begin
        if (sample_valid) begin
          force_reg_next = force_db;
          if (force_db > peak_reg) begin
            peak_reg_next = force_db;
          end
          if (force_db >= break_counts) begin
            break_reg_next = peak_reg_next;
            phase_reg_next = PH_BROKEN;
            brk_reg_next   = 1'b1;
          end
        end
      end
      PH_BROKEN: begin
        if (pressed) begin
          settle_count_next = '0;
          tare_count_next   = '0;
          tare_sum_next     = '0;
          phase_reg_next    = PH_SETTLE;
        end
      end
      default: begin
        phase_reg_next = PH_SETTLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband_counts <= DEF_DEADBAND;
      break_counts    <= DEF_BREAK;
      debounce_limit  <= DEF_DEBOUNCE;
      settle_ms       <= DEF_SETTLE;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DEADBAND: deadband_counts <= cfg_data[FORCE_W-1:0];
        CFG_BREAK:    break_counts    <= cfg_data[FORCE_W-1:0];
        CFG_DEBOUNCE: debounce_limit  <= cfg_data[DEBOUNCE_W-1:0];
        CFG_SETTLE:   settle_ms       <= cfg_data[SETTLE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg       <= PH_SETTLE;
      settle_count    <= '0;
      tare_count      <= '0;
      tare_sum        <= '0;
      offset_reg      <= '0;
      force_reg       <= '0;
      peak_reg        <= '0;
      break_reg       <= '0;
      last_raw_level  <= 1'b1;
      stable_level    <= 1'b1;
      since_change_ms <= '0;
      brk_reg         <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (accept) begin
        phase_reg       <= phase_reg_next;
        settle_count    <= settle_count_next;
        tare_count      <= tare_count_next;
        tare_sum        <= tare_sum_next;
        offset_reg      <= offset_reg_next;
        force_reg       <= force_reg_next;
        peak_reg        <= peak_reg_next;
        break_reg       <= break_reg_next;
        last_raw_level  <= last_raw_level_next;
        stable_level    <= stable_level_next;
        since_change_ms <= since_change_ms_next;
        brk_reg         <= brk_reg_next;
        out_valid       <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign offset_ext   = EXT_W'(offset_reg);
  assign phase        = phase_reg;
  assign force_counts = force_reg;
  assign peak_counts  = peak_reg;
  assign break_force  = break_reg;
  assign break_event  = brk_reg;
  assign zero_offset  = offset_ext[FORCE_W-1:0];

endmodule

`default_nettype wire

// File: hw/rtl/fpbd_checker.sv
// Port-level checker of the force peak and break detector and its bind.
`default_nettype none

`include "force_peak_break_detector_defines.svh"

module fpbd_checker
  import fpbd_pkg::*;
(
  input wire                 clk,
  input wire                 rst,
  input wire                 out_valid,
  input wire [PHASE_W-1:0]   phase,
  input wire [FORCE_W-1:0]   force_counts,
  input wire [FORCE_W-1:0]   peak_counts,
  input wire [FORCE_W-1:0]   break_force,
  input wire                 break_event
);

  `FPBD_CHECK_RST(a_reset_empty, rst |=> !out_valid, "result shown after reset")
  `FPBD_CHECK(a_break_phase, out_valid && break_event |-> phase == PH_BROKEN, "bad break phase")
  `FPBD_CHECK(a_break_peak, break_event |-> break_force == peak_counts, "break force not peak")
  `FPBD_CHECK(a_peak_bound, out_valid |-> force_counts <= peak_counts, "force above peak")

endmodule

bind force_peak_break_detector fpbd_checker u_fpbd_checker (.*);

`default_nettype wire
